/* design/bpp_pkg.sv */
package bpp_pkg;

  localparam int unsigned VM_COUNT    = 8;
  localparam int unsigned PAGE_LIMIT  = 4096;
  localparam int unsigned VM_W        = $clog2(VM_COUNT);
  localparam int unsigned CNT_W       = $clog2(VM_COUNT + 1);
  localparam int unsigned PAGE_W      = 13;
  localparam int unsigned SUM_W       = PAGE_W + 1;
  localparam int unsigned STRESS_W    = 2;
  localparam int unsigned ACT_W       = 4;
  localparam int unsigned CEIL_W      = 13;
  localparam int unsigned GROW_W      = 12;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned TRIM_PERIOD = 4;
  localparam int unsigned PHASE_W     = $clog2(TRIM_PERIOD);
  localparam int unsigned UC_DEPTH    = 8;
  localparam int unsigned UC_W        = $clog2(UC_DEPTH);

  localparam logic [ACT_W-1:0]   ACTIVE_VMS_RST   = ACT_W'(1);
  localparam logic [CEIL_W-1:0]  PAGE_CEILING_RST = CEIL_W'(200);
  localparam logic [GROW_W-1:0]  GROW_STEP_RST    = GROW_W'(10);
  localparam logic [PHASE_W-1:0] PHASE_LAST       = PHASE_W'(TRIM_PERIOD - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_VMS   = 2'd0,
    CFG_PAGE_CEILING = 2'd1,
    CFG_GROW_STEP    = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_REPORT = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [STRESS_W-1:0] {
    STRESS_NONE = 2'd0,
    STRESS_LOW  = 2'd1,
    STRESS_CRIT = 2'd2
  } stress_e;

  typedef enum logic {
    ACT_INFLATE = 1'b0,
    ACT_DEFLATE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    CAUSE_RELIEF = 2'd0,
    CAUSE_IDLE   = 2'd1,
    CAUSE_TRIM   = 2'd2
  } cause_e;

  typedef enum logic [1:0] {
    SCAN_NONE   = 2'd0,
    SCAN_STRESS = 2'd1,
    SCAN_MIN    = 2'd2,
    SCAN_MAX    = 2'd3
  } scan_e;

  typedef enum logic [1:0] {
    EVAL_NONE   = 2'd0,
    EVAL_RELIEF = 2'd1,
    EVAL_IDLE   = 2'd2,
    EVAL_TRIM   = 2'd3
  } eval_e;

  typedef enum logic [1:0] {
    COND_NEXT     = 2'd0,
    COND_MORE     = 2'd1,
    COND_PHASE_NZ = 2'd2
  } cond_e;

  typedef struct packed {
    scan_e           scan;
    eval_e           eval;
    logic            phase_adv;
    logic            flush;
    cond_e           cond;
    logic [UC_W-1:0] target;
    logic            done;
  } ctl_t;

  typedef struct packed {
    logic hold;
    logic scan_last;
    logic phase_nz;
  } stat_t;

  typedef struct packed {
    logic                we;
    logic [VM_W-1:0]     slot;
    logic [PAGE_W-1:0]   pages;
    logic [STRESS_W-1:0] stress;
  } rpt_t;

  localparam ctl_t UC_NOP = '{
    scan: SCAN_NONE, eval: EVAL_NONE, phase_adv: 1'b0, flush: 1'b0,
    cond: COND_NEXT, target: '0, done: 1'b0
  };

  // program addresses
  localparam logic [UC_W-1:0] UC_SCAN_STRESS = UC_W'(0);
  localparam logic [UC_W-1:0] UC_RELIEF      = UC_W'(1);
  localparam logic [UC_W-1:0] UC_SCAN_MIN    = UC_W'(2);
  localparam logic [UC_W-1:0] UC_IDLE        = UC_W'(3);
  localparam logic [UC_W-1:0] UC_PHASE       = UC_W'(4);
  localparam logic [UC_W-1:0] UC_SCAN_MAX    = UC_W'(5);
  localparam logic [UC_W-1:0] UC_TRIM        = UC_W'(6);
  localparam logic [UC_W-1:0] UC_FLUSH       = UC_W'(7);

  function automatic ctl_t uc_word(logic [UC_W-1:0] step);
    ctl_t w;
    w = UC_NOP;
    case (step)
      UC_SCAN_STRESS: begin
        w.scan   = SCAN_STRESS;
        w.cond   = COND_MORE;
        w.target = UC_SCAN_STRESS;
      end
      UC_RELIEF: begin
        w.eval = EVAL_RELIEF;
      end
      UC_SCAN_MIN: begin
        w.scan   = SCAN_MIN;
        w.cond   = COND_MORE;
        w.target = UC_SCAN_MIN;
      end
      UC_IDLE: begin
        w.eval = EVAL_IDLE;
      end
      UC_PHASE: begin
        // trim only on the tick where the phase wraps
        w.phase_adv = 1'b1;
        w.cond      = COND_PHASE_NZ;
        w.target    = UC_FLUSH;
      end
      UC_SCAN_MAX: begin
        w.scan   = SCAN_MAX;
        w.cond   = COND_MORE;
        w.target = UC_SCAN_MAX;
      end
      UC_TRIM: begin
        w.eval = EVAL_TRIM;
      end
      UC_FLUSH: begin
        w.flush = 1'b1;
        w.done  = 1'b1;
      end
      default: begin
        w = UC_NOP;
      end
    endcase
    return w;
  endfunction

endpackage

/* design/bpp_seq.sv */
module bpp_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  bpp_pkg::stat_t stat_i,
  output bpp_pkg::ctl_t  ctl_o,
  output logic           busy_o
);
  import bpp_pkg::*;

  logic            run_q, run_d;
  logic [UC_W-1:0] step_q, step_d;
  ctl_t            word;
  logic            taken;

  assign word = uc_word(step_q);

  always_comb begin
    case (word.cond)
      COND_MORE:     taken = !stat_i.scan_last;
      COND_PHASE_NZ: taken = stat_i.phase_nz;
      default:       taken = 1'b0;
    endcase
  end

  always_comb begin
    run_d  = run_q;
    step_d = step_q;
    if (!run_q) begin
      if (start_i) begin
        run_d  = 1'b1;
        step_d = UC_SCAN_STRESS;
      end
    end else if (!stat_i.hold) begin
      if (word.done) begin
        run_d = 1'b0;
      end else if (taken) begin
        step_d = word.target;
      end else begin
        step_d = step_q + UC_W'(1);
      end
    end
  end

  always_comb begin
    ctl_o  = run_q ? word : UC_NOP;
    busy_o = run_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
    end
  end

endmodule

/* design/bpp_dpath.sv */
module bpp_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpp_pkg::ctl_t                 ctl_i,
  output bpp_pkg::stat_t                stat_o,
  input  bpp_pkg::rpt_t                 rpt_i,
  input  logic [bpp_pkg::ACT_W-1:0]     active_vms_i,
  input  logic [bpp_pkg::CEIL_W-1:0]    page_ceiling_i,
  input  logic [bpp_pkg::GROW_W-1:0]    grow_step_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [bpp_pkg::VM_W-1:0]      target_vm_o,
  output logic                          action_o,
  output logic [bpp_pkg::PAGE_W-1:0]    goal_pages_o,
  output logic [1:0]                    cause_o,
  output logic                          final_res_o
);
  import bpp_pkg::*;

  logic [PAGE_W-1:0]   page_q   [VM_COUNT];
  logic [STRESS_W-1:0] stress_q [VM_COUNT];
  logic [PHASE_W-1:0]  phase_q;

  logic [VM_W-1:0]     idx_q;
  logic [VM_W-1:0]     sel_q;
  logic [STRESS_W-1:0] worst_q;
  logic [PAGE_W-1:0]   best_q;

  logic                pend_vld_q;
  logic [VM_W-1:0]     pend_vm_q;
  logic                pend_act_q;
  logic [PAGE_W-1:0]   pend_goal_q;
  logic [1:0]          pend_cause_q;

  logic                out_vld_q, out_vld_d;
  logic [VM_W-1:0]     out_vm_q;
  logic                out_act_q;
  logic [PAGE_W-1:0]   out_goal_q;
  logic [1:0]          out_cause_q;
  logic                out_fin_q;

  logic [CNT_W-1:0]    n_eff;
  logic [CEIL_W-1:0]   ceil_eff;
  logic [VM_W-1:0]     rd_addr;
  logic [PAGE_W-1:0]   rd_page;
  logic [STRESS_W-1:0] rd_st;
  logic                first, last;
  logic [SUM_W-1:0]    grow_sum;

  logic                eval_on, cmd_issue, cmd_act;
  logic [PAGE_W-1:0]   cmd_goal;
  logic [1:0]          cmd_cause;
  logic                out_free, hold, commit, flush_go, out_load;

  always_comb begin
    if (active_vms_i == '0) begin
      n_eff = CNT_W'(1);
    end else if (active_vms_i > ACT_W'(VM_COUNT)) begin
      n_eff = CNT_W'(VM_COUNT);
    end else begin
      n_eff = CNT_W'(active_vms_i);
    end
    ceil_eff = (page_ceiling_i > CEIL_W'(PAGE_LIMIT)) ? CEIL_W'(PAGE_LIMIT) : page_ceiling_i;
  end

  // scans walk the records, evaluation steps look at the chosen VM
  assign rd_addr = (ctl_i.scan != SCAN_NONE) ? idx_q : sel_q;
  assign rd_page = page_q[rd_addr];
  assign rd_st   = stress_q[rd_addr];
  assign first   = (idx_q == '0);
  assign last    = (CNT_W'(idx_q) == (n_eff - CNT_W'(1)));
  assign grow_sum = {1'b0, rd_page} + SUM_W'(grow_step_i);

  always_comb begin
    eval_on   = (ctl_i.eval != EVAL_NONE);
    cmd_issue = 1'b0;
    cmd_goal  = '0;
    cmd_act   = ACT_INFLATE;
    cmd_cause = CAUSE_RELIEF;
    case (ctl_i.eval)
      EVAL_RELIEF: begin
        cmd_issue = (worst_q != STRESS_NONE) && (rd_page != '0);
        cmd_goal  = (worst_q == STRESS_CRIT) ? '0 : (rd_page >> 1);
        cmd_act   = ACT_DEFLATE;
        cmd_cause = CAUSE_RELIEF;
      end
      EVAL_IDLE: begin
        cmd_issue = (grow_sum <= {1'b0, ceil_eff});
        cmd_goal  = grow_sum[PAGE_W-1:0];
        cmd_act   = ACT_INFLATE;
        cmd_cause = CAUSE_IDLE;
      end
      EVAL_TRIM: begin
        cmd_issue = (rd_page != '0);
        cmd_goal  = rd_page >> 1;
        cmd_act   = ACT_DEFLATE;
        cmd_cause = CAUSE_TRIM;
      end
      default: begin
        cmd_issue = 1'b0;
      end
    endcase
  end

  // one command is held back so the last of a tick can carry the final flag
  always_comb begin
    out_free = !out_vld_q || !out_stall_i;
    hold     = pend_vld_q && !out_free && ((eval_on && cmd_issue) || ctl_i.flush);
    commit   = eval_on && cmd_issue && !hold;
    flush_go = ctl_i.flush && pend_vld_q && !hold;
    out_load = (commit && pend_vld_q) || flush_go;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_comb begin
    stat_o.hold      = hold;
    stat_o.scan_last = last;
    stat_o.phase_nz  = (phase_q != PHASE_LAST);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VM_COUNT; i++) begin
        page_q[i]   <= '0;
        stress_q[i] <= STRESS_NONE;
      end
      phase_q    <= '0;
      idx_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (rpt_i.we) begin
        page_q[rpt_i.slot]   <= rpt_i.pages;
        stress_q[rpt_i.slot] <= rpt_i.stress;
      end else if (commit) begin
        page_q[sel_q] <= cmd_goal;
      end
      if (ctl_i.phase_adv) begin
        phase_q <= phase_q + PHASE_W'(1);
      end
      if (ctl_i.scan != SCAN_NONE) begin
        idx_q <= last ? '0 : idx_q + VM_W'(1);
      end
      if (commit) begin
        pend_vld_q <= 1'b1;
      end else if (flush_go) begin
        pend_vld_q <= 1'b0;
      end
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.scan)
      SCAN_STRESS: begin
        if (first || (rd_st > worst_q)) begin
          worst_q <= rd_st;
          sel_q   <= idx_q;
        end
      end
      SCAN_MIN: begin
        if (first || (rd_page < best_q)) begin
          best_q <= rd_page;
          sel_q  <= idx_q;
        end
      end
      SCAN_MAX: begin
        if (first || (rd_page > best_q)) begin
          best_q <= rd_page;
          sel_q  <= idx_q;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_vm_q    <= pend_vm_q;
      out_act_q   <= pend_act_q;
      out_goal_q  <= pend_goal_q;
      out_cause_q <= pend_cause_q;
      out_fin_q   <= flush_go;
    end
    if (commit) begin
      pend_vm_q    <= sel_q;
      pend_act_q   <= cmd_act;
      pend_goal_q  <= cmd_goal;
      pend_cause_q <= cmd_cause;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign target_vm_o  = out_vm_q;
  assign action_o     = out_act_q;
  assign goal_pages_o = out_goal_q;
  assign cause_o      = out_cause_q;
  assign final_res_o  = out_fin_q;

endmodule

/* design/balloon_page_policy.sv */
// Balloon page policy for up to eight VMs. A report beat (op 0) overwrites one
// VM's page and pressure record in the cycle it is accepted and gives no result.
// A tick beat (op 1) runs a short microcode program over the records: a pressure
// scan, an idle-inflate scan and, on every fourth tick, a trim scan, each
// followed by one evaluation step that may issue a command. A scan visits the
// records of the active VMs (active_vms clamped to 1..8) one at a time, since
// the records are read through a single port. The input stays stalled while
// the program runs, also while a command waits on a stalled output register.
// Up to three command beats follow a tick; the last one has final_res set.
// Configuration may be written only while the block is idle.
module balloon_page_policy (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bpp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bpp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic [2:0]                       vm_slot_i,
  input  logic [12:0]                      held_pages_i,
  input  logic [1:0]                       stress_level_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [2:0]                       target_vm_o,
  output logic                             action_o,
  output logic [12:0]                      goal_pages_o,
  output logic [1:0]                       cause_o,
  output logic                             final_res_o
);
  import bpp_pkg::*;

  logic [ACT_W-1:0]  active_vms_q;
  logic [CEIL_W-1:0] page_ceiling_q;
  logic [GROW_W-1:0] grow_step_q;

  logic  busy, in_acc, start;
  rpt_t  rpt;
  ctl_t  ctl;
  stat_t stat;

  assign in_stall_o = busy;
  assign in_acc     = in_valid_i && !busy;
  assign start      = in_acc && (op_i == OP_TICK);

  // report clamping: oversized page counts and the unused pressure code
  always_comb begin
    rpt.we     = in_acc && (op_i == OP_REPORT);
    rpt.slot   = VM_W'(vm_slot_i);
    rpt.pages  = (held_pages_i > PAGE_W'(PAGE_LIMIT)) ? PAGE_W'(PAGE_LIMIT)
                                                       : PAGE_W'(held_pages_i);
    rpt.stress = (stress_level_i > STRESS_CRIT) ? STRESS_CRIT : stress_level_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_vms_q   <= ACTIVE_VMS_RST;
      page_ceiling_q <= PAGE_CEILING_RST;
      grow_step_q    <= GROW_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ACTIVE_VMS:   active_vms_q   <= cfg_data_i[ACT_W-1:0];
        CFG_PAGE_CEILING: page_ceiling_q <= cfg_data_i[CEIL_W-1:0];
        CFG_GROW_STEP:    grow_step_q    <= cfg_data_i[GROW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bpp_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctl_o   (ctl),
    .busy_o  (busy)
  );

  bpp_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .rpt_i          (rpt),
    .active_vms_i   (active_vms_q),
    .page_ceiling_i (page_ceiling_q),
    .grow_step_i    (grow_step_q),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .target_vm_o    (target_vm_o),
    .action_o       (action_o),
    .goal_pages_o   (goal_pages_o),
    .cause_o        (cause_o),
    .final_res_o    (final_res_o)
  );

endmodule
